>>> src/tcq_pkg.sv
package tcq_pkg;

  localparam int unsigned ClassDepth = 16;
  localparam int unsigned PtrW = $clog2(ClassDepth);
  localparam int unsigned CntW = $clog2(ClassDepth + 1);

  localparam logic [1:0] FuncEnq   = 2'd0;
  localparam logic [1:0] FuncPop   = 2'd1;
  localparam logic [1:0] FuncCmpl  = 2'd2;
  localparam logic [1:0] FuncClose = 2'd3;

  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StClosing = 3'd1;
  localparam logic [2:0] StCount   = 3'd2;
  localparam logic [2:0] StBytes   = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;
  localparam logic [2:0] StFlushed = 3'd5;

  localparam logic [1:0] RegMaxOps   = 2'd0;
  localparam logic [1:0] RegMaxBytes = 2'd1;
  localparam logic [1:0] RegStreak   = 2'd2;
  localparam logic [1:0] RegWait     = 2'd3;

  // Entry field layout in the class RAM: seq, bytes, time.
  localparam int unsigned EntryW = 96;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       latch;    // capture the item fields
    logic       rd_hi;    // issue head reads
    logic       exec;     // perform the single-step operation
    logic       flush_hi; // pop one high entry as flush
    logic       flush_lo; // pop one low entry as flush
    logic       flush_end;
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic is_close;
    logic hi_empty;
    logic lo_empty;
    logic hi_one;
    logic lo_one;
  } stat_t;

endpackage

>>> src/tcq_ram.sv
module tcq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/tcq_ctrl.sv
module tcq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tcq_pkg::stat_t stat_i,
  output tcq_pkg::cmd_t  cmd_o,
  output logic          busy_o
);
  import tcq_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SExec  = 3'd2;
  localparam logic [2:0] SFlHi  = 3'd3;
  localparam logic [2:0] SFlLo  = 3'd4;
  localparam logic [2:0] SFlEnd = 3'd5;

  logic [2:0] state_q, state_d;

  // Sequence one item: read heads, then execute or walk the flush.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      SIdle: begin
        cmd_o.latch = start_i;
        if (start_i) state_d = SRead;
      end
      SRead: begin
        cmd_o.rd_hi = 1'b1;
        state_d = SExec;
      end
      SExec: begin
        if (!stat_i.is_close || (stat_i.hi_empty && stat_i.lo_empty)) begin
          cmd_o.exec = 1'b1;
          state_d = SIdle;
        end else if (!stat_i.hi_empty) begin
          state_d = SFlHi;
        end else begin
          state_d = SFlLo;
        end
      end
      SFlHi: begin
        cmd_o.flush_hi = 1'b1;
        if (stat_i.hi_one) state_d = stat_i.lo_empty ? SFlEnd : SFlLo;
      end
      SFlLo: begin
        cmd_o.flush_lo = 1'b1;
        if (stat_i.lo_one) state_d = SFlEnd;
      end
      SFlEnd: begin
        cmd_o.flush_end = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != SIdle);
endmodule

>>> src/tcq_dp.sv
module tcq_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcq_pkg::cmd_t  cmd_i,
  output tcq_pkg::stat_t stat_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  input  logic [1:0]     func_i,
  input  logic           high_class_i,
  input  logic [31:0]    byte_count_i,
  input  logic [31:0]    now_ms_i,
  output logic           res_valid_o,
  output logic [2:0]     status_o,
  output logic [31:0]    sequence_res_o,
  output logic [31:0]    bytes_out_o,
  output logic           served_high_o,
  output logic           rescued_o,
  output logic [5:0]     pending_total_o,
  output logic           last_o
);
  import tcq_pkg::*;

  logic [4:0]  max_ops_q;
  logic [31:0] max_bytes_q;
  logic [7:0]  streak_lim_q;
  logic [15:0] wait_thr_q;

  logic [1:0]  func_q;
  logic        hi_q;
  logic [31:0] bytes_q, now_q;

  logic [PtrW-1:0] hh_q, ht_q, lh_q, lt_q;
  logic [CntW-1:0] hc_q, lc_q;
  logic [32:0] pend_q, act_q;
  logic [7:0]  streak_q;
  logic [31:0] seq_q;
  logic        open_q;

  logic [EntryW-1:0] hi_rd, lo_rd;
  logic hi_we, lo_we;
  logic [PtrW-1:0] hi_ra, lo_ra;

  // Capture configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ops_q <= 5'd16; max_bytes_q <= '1; streak_lim_q <= 8'd4; wait_thr_q <= 16'd250;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxOps:   max_ops_q <= cfg_data_i[4:0];
        RegMaxBytes: max_bytes_q <= cfg_data_i;
        RegStreak:   streak_lim_q <= cfg_data_i[7:0];
        RegWait:     wait_thr_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Hold the item fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i; hi_q <= high_class_i; bytes_q <= byte_count_i; now_q <= now_ms_i;
    end
  end

  // During a flush the read address runs one entry ahead of the head.
  logic hi_adv, lo_adv;
  assign hi_ra = (cmd_i.flush_hi) ? hh_q + PtrW'(1) : hh_q;
  assign lo_ra = (cmd_i.flush_lo) ? lh_q + PtrW'(1) : lh_q;

  tcq_ram #(.Width(EntryW), .Depth(ClassDepth)) u_hi (
    .clk_i, .we_i(hi_we), .waddr_i(ht_q), .wdata_i({seq_q, bytes_q, now_q}),
    .raddr_i(hi_ra), .rdata_o(hi_rd));
  tcq_ram #(.Width(EntryW), .Depth(ClassDepth)) u_lo (
    .clk_i, .we_i(lo_we), .waddr_i(lt_q), .wdata_i({seq_q, bytes_q, now_q}),
    .raddr_i(lo_ra), .rdata_o(lo_rd));

  logic [5:0] total;
  assign total = 6'(hc_q) + 6'(lc_q);

  // Admission checks.
  logic closed, cnt_bad, byte_bad, enq_ok;
  logic [33:0] need;
  assign need = 34'(pend_q) + 34'(act_q) + 34'(bytes_q);
  assign closed = !open_q;
  assign cnt_bad = (total >= 6'(max_ops_q)) ||
                   (hi_q ? (hc_q == CntW'(ClassDepth)) : (lc_q == CntW'(ClassDepth)));
  assign byte_bad = need > 34'(max_bytes_q);
  assign enq_ok = !closed && !cnt_bad && !byte_bad;

  // Pop choice.
  logic [31:0] age;
  logic rescue, pop_hi, pop_lo;
  assign age = now_q - lo_rd[31:0];
  assign rescue = (lc_q != 0) && (streak_q >= streak_lim_q) && (age >= 32'(wait_thr_q));
  assign pop_hi = !rescue && (hc_q != 0);
  assign pop_lo = rescue || (!pop_hi && lc_q != 0);

  logic do_enq, do_pop;
  assign do_enq = cmd_i.exec && func_q == FuncEnq && enq_ok;
  assign do_pop = cmd_i.exec && func_q == FuncPop;
  assign hi_we = do_enq && hi_q;
  assign lo_we = do_enq && !hi_q;
  assign hi_adv = (do_pop && pop_hi) || cmd_i.flush_hi;
  assign lo_adv = (do_pop && pop_lo) || cmd_i.flush_lo;

  logic [31:0] pb;
  assign pb = pop_hi ? hi_rd[63:32] : lo_rd[63:32];

  // Update queue state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hh_q <= '0; ht_q <= '0; lh_q <= '0; lt_q <= '0; hc_q <= '0; lc_q <= '0;
      pend_q <= '0; act_q <= '0; streak_q <= '0; seq_q <= 32'd1; open_q <= 1'b1;
    end else begin
      if (hi_we) begin ht_q <= ht_q + PtrW'(1); hc_q <= hc_q + CntW'(1); end
      if (lo_we) begin lt_q <= lt_q + PtrW'(1); lc_q <= lc_q + CntW'(1); end
      if (do_enq) begin
        seq_q <= seq_q + 32'd1;
        pend_q <= pend_q + 33'(bytes_q);
      end
      if (hi_adv) begin hh_q <= hh_q + PtrW'(1); hc_q <= hc_q - CntW'(1); end
      if (lo_adv) begin lh_q <= lh_q + PtrW'(1); lc_q <= lc_q - CntW'(1); end
      if (do_pop && (pop_hi || pop_lo)) begin
        pend_q <= (pend_q >= 33'(pb)) ? pend_q - 33'(pb) : '0;
        act_q <= act_q + 33'(pb);
        if (pop_hi) begin
          if (streak_q != 8'hFF) streak_q <= streak_q + 8'd1;
        end else streak_q <= '0;
      end
      if (cmd_i.exec && func_q == FuncCmpl)
        act_q <= (act_q >= 33'(bytes_q)) ? act_q - 33'(bytes_q) : '0;
      if ((cmd_i.exec && func_q == FuncClose) || cmd_i.flush_end) begin
        open_q <= 1'b0; pend_q <= '0;
      end
    end
  end

  // Drive one result per step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_o <= 1'b0;
    else res_valid_o <= cmd_i.exec || cmd_i.flush_hi || cmd_i.flush_lo;
  end

  logic [2:0]  status_d;
  logic [31:0] seq_res_d, bytes_res_d;
  logic        hi_res_d, resc_res_d, last_d;
  logic [5:0]  total_res_d;

  // Form the result of the current step.
  always_comb begin
    status_d = StDone; seq_res_d = '0; bytes_res_d = '0;
    hi_res_d = 1'b0; resc_res_d = 1'b0; total_res_d = total; last_d = 1'b1;
    if (cmd_i.flush_hi || cmd_i.flush_lo) begin
      status_d = StFlushed;
      seq_res_d = cmd_i.flush_hi ? hi_rd[95:64] : lo_rd[95:64];
      bytes_res_d = cmd_i.flush_hi ? hi_rd[63:32] : lo_rd[63:32];
      hi_res_d = cmd_i.flush_hi;
      total_res_d = '0;
      last_d = cmd_i.flush_hi ? (hc_q == CntW'(1) && lc_q == 0) : (lc_q == CntW'(1));
    end else begin
      case (func_q)
        FuncEnq: begin
          if (closed) status_d = StClosing;
          else if (cnt_bad) status_d = StCount;
          else if (byte_bad) status_d = StBytes;
          else begin
            seq_res_d = seq_q;
            total_res_d = total + 6'd1;
          end
        end
        FuncPop: begin
          if (!(pop_hi || pop_lo)) begin
            status_d = StEmpty; total_res_d = '0;
          end else begin
            seq_res_d = pop_hi ? hi_rd[95:64] : lo_rd[95:64];
            bytes_res_d = pb; hi_res_d = pop_hi; resc_res_d = rescue;
            total_res_d = total - 6'd1;
          end
        end
        FuncClose: total_res_d = '0;
        default: ;
      endcase
    end
  end

  // Register the result.
  always_ff @(posedge clk_i) begin
    status_o <= status_d; sequence_res_o <= seq_res_d; bytes_out_o <= bytes_res_d;
    served_high_o <= hi_res_d; rescued_o <= resc_res_d; pending_total_o <= total_res_d;
    last_o <= last_d;
  end

  assign stat_o.is_close = (func_q == FuncClose);
  assign stat_o.hi_empty = (hc_q == 0);
  assign stat_o.lo_empty = (lc_q == 0);
  assign stat_o.hi_one = (hc_q == CntW'(1));
  assign stat_o.lo_one = (lc_q == CntW'(1));
endmodule

>>> src/two_class_queue_with_starvation_guard.sv
// Enqueue, pop and complete give their one result after the read and execute states;
// a new item is taken only while busy is low. Close flushes the N waiting entries,
// one flushed item per cycle from the class RAM read port.
// The receiver cannot stall: each result is shown for one cycle with done_o.
// Reset (rst_ni low, asynchronous) empties both queues, opens admission,
// restores register defaults and sets the next sequence number to one.
module two_class_queue_with_starvation_guard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  func_i,
  input  logic        high_class_i,
  input  logic [31:0] byte_count_i,
  input  logic [31:0] now_ms_i,
  input  logic [1:0]  outcome_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] sequence_res_o,
  output logic [31:0] bytes_out_o,
  output logic        served_high_o,
  output logic        rescued_o,
  output logic [5:0]  pending_total_o,
  output logic        last_o
);
  import tcq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  unused_outcome;
  assign unused_outcome = ^outcome_i;

  tcq_ctrl u_ctrl (.clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd),
                   .busy_o(busy));

  tcq_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .func_i, .high_class_i, .byte_count_i, .now_ms_i,
    .res_valid_o(done_o), .status_o, .sequence_res_o, .bytes_out_o,
    .served_high_o, .rescued_o, .pending_total_o, .last_o);

`ifndef SYNTHESIS
  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !done_o || $past(busy)) else $error("result without work");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && last_o |-> !cmd.flush_hi && !cmd.flush_lo) else $error("flush past last");
  a_flush_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StFlushed |-> pending_total_o == 6'd0) else $error("flush total");
`endif
endmodule
